>>> rtl/bptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared constants, register map and stage payload types for the
// barometric pressure / temperature compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

   localparam int NUM_STAGES = 9;

   // stage indexes into the pipeline enable vector
   localparam int STG_DT    = 0;
   localparam int STG_MUL   = 1;
   localparam int STG_FIRST = 2;
   localparam int STG_SQ    = 3;
   localparam int STG_CORR  = 4;
   localparam int STG_APPLY = 5;
   localparam int STG_PPROD = 6;
   localparam int STG_PSUM  = 7;
   localparam int STG_OUT   = 8;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_SENS     = 3'd0;
   localparam logic [2:0] REG_OFF      = 3'd1;
   localparam logic [2:0] REG_TCS      = 3'd2;
   localparam logic [2:0] REG_TCO      = 3'd3;
   localparam logic [2:0] REG_TREF     = 3'd4;
   localparam logic [2:0] REG_TEMPSENS = 3'd5;

   localparam logic [1:0] REGION_NORMAL = 2'd0;
   localparam logic [1:0] REGION_LOW    = 2'd1;
   localparam logic [1:0] REGION_VLOW   = 2'd2;

   localparam logic signed [19:0] TEMP_REF   = 20'sd2000;
   localparam logic signed [19:0] VLOW_SHIFT = 20'sd3500;
   localparam logic signed [18:0] VLOW_LIMIT = -19'sd3500;

   typedef struct packed {
      logic [15:0] c1;
      logic [15:0] c2;
      logic [15:0] c3;
      logic [15:0] c4;
      logic [15:0] c5;
      logic [15:0] c6;
   } coeff_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
   } pipe_ctrl_type;

   typedef struct packed {
      logic [23:0] d1;
      logic [19:0] temp;
      logic [17:0] t2;
      logic [35:0] off;
      logic [34:0] sens;
      logic [1:0]  region;
      logic [35:0] sq1;
      logic [35:0] sq2;
   } first_out_type;

   typedef struct packed {
      logic [23:0] d1;
      logic [20:0] temp;
      logic [40:0] off;
      logic [40:0] sens;
      logic [1:0]  region;
   } second_out_type;

endpackage

>>> rtl/bptc_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_csr
// APB-style register file holding the six calibration words.
// ----------------------------------------------------------------------------
module bptc_csr
   import bptc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output coeff_type             coeff
);

   coeff_type   coeff_ff;
   coeff_type   coeff_in;
   logic [2:0]  index;
   logic        wr_en;
   logic [15:0] wdata;
   logic [15:0] rdata;

   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign wdata      = csr_pwdata[15:0];
   assign csr_pready = 1'b1;
   assign coeff      = coeff_ff;
   assign csr_prdata = {16'h0, rdata};

   always_comb begin
      coeff_in = coeff_ff;
      if (wr_en) begin
         case (index)
            REG_SENS:     coeff_in.c1 = wdata;
            REG_OFF:      coeff_in.c2 = wdata;
            REG_TCS:      coeff_in.c3 = wdata;
            REG_TCO:      coeff_in.c4 = wdata;
            REG_TREF:     coeff_in.c5 = wdata;
            REG_TEMPSENS: coeff_in.c6 = wdata;
            default:      coeff_in = coeff_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_SENS:     rdata = coeff_ff.c1;
         REG_OFF:      rdata = coeff_ff.c2;
         REG_TCS:      rdata = coeff_ff.c3;
         REG_TCO:      rdata = coeff_ff.c4;
         REG_TREF:     rdata = coeff_ff.c5;
         REG_TEMPSENS: rdata = coeff_ff.c6;
         default:      rdata = 16'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
      end else begin
         coeff_ff <= coeff_in;
      end
   end

endmodule

>>> rtl/bptc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_ctrl
// Valid bits and per-stage load enables; a stage loads when it is empty or
// the stage after it moves, so bubbles collapse under backpressure.
// ----------------------------------------------------------------------------
module bptc_ctrl
   import bptc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output pipe_ctrl_type pipe
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] ready;

   always_comb begin
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ready[0]) begin
         valid_in[0] = req_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign pipe.en    = ready;
   assign req_tready = ready[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];

endmodule

>>> rtl/bptc_first.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_first
// First-order terms: dT, the four dT products, TEMP/OFF/SENS/T2, region,
// and the two squares for the low-temperature correction.
// ----------------------------------------------------------------------------
module bptc_first
   import bptc_pkg::*;
(
   input  logic                  clock,
   input  pipe_ctrl_type         pipe,
   input  coeff_type             coeff,
   input  logic [23:0]           pressure_raw,
   input  logic [23:0]           temperature_raw,
   output first_out_type         first_out
);

   // stage 1
   logic [23:0]        d1_s1_ff;
   logic signed [24:0] dt_s1_ff;
   logic signed [24:0] dt_s1_in;

   // stage 2
   logic [23:0]        d1_s2_ff;
   logic signed [41:0] pt_s2_ff, pt_s2_in;
   logic signed [41:0] po_s2_ff, po_s2_in;
   logic signed [41:0] ps_s2_ff, ps_s2_in;
   logic signed [49:0] dsq_s2_ff, dsq_s2_in;

   // stage 3
   logic [23:0]        d1_s3_ff;
   logic signed [18:0] sh;
   logic signed [19:0] temp_s3_ff, temp_s3_in;
   logic signed [18:0] a_s3_ff;
   logic signed [19:0] b_s3_ff, b_s3_in;
   logic signed [35:0] off_s3_ff, off_s3_in;
   logic signed [34:0] sens_s3_ff, sens_s3_in;
   logic [17:0]        t2_s3_ff;
   logic [1:0]         region_s3_ff, region_s3_in;

   // stage 4
   first_out_type      out_ff, out_in;
   logic signed [37:0] sq1_full;
   logic signed [39:0] sq2_full;

   assign dt_s1_in = $signed({1'b0, temperature_raw}) - $signed({1'b0, coeff.c5, 8'h00});

   always_ff @(posedge clock) begin
      if (pipe.en[STG_DT]) begin
         d1_s1_ff <= pressure_raw;
         dt_s1_ff <= dt_s1_in;
      end
   end

   assign pt_s2_in  = dt_s1_ff * $signed({1'b0, coeff.c6});
   assign po_s2_in  = dt_s1_ff * $signed({1'b0, coeff.c4});
   assign ps_s2_in  = dt_s1_ff * $signed({1'b0, coeff.c3});
   assign dsq_s2_in = dt_s1_ff * dt_s1_ff;

   always_ff @(posedge clock) begin
      if (pipe.en[STG_MUL]) begin
         d1_s2_ff  <= d1_s1_ff;
         pt_s2_ff  <= pt_s2_in;
         po_s2_ff  <= po_s2_in;
         ps_s2_ff  <= ps_s2_in;
         dsq_s2_ff <= dsq_s2_in;
      end
   end

   // sh = TEMP - 2000
   assign sh         = $signed(pt_s2_ff[41:23]);
   assign temp_s3_in = $signed({sh[18], sh}) + TEMP_REF;
   assign b_s3_in    = $signed({sh[18], sh}) + VLOW_SHIFT;
   assign off_s3_in  = $signed({4'h0, coeff.c2, 16'h0000})
                     + $signed({po_s2_ff[41], po_s2_ff[41:7]});
   assign sens_s3_in = $signed({4'h0, coeff.c1, 15'h0000})
                     + $signed({ps_s2_ff[41], ps_s2_ff[41:8]});

   always_comb begin
      if (!sh[18]) begin
         region_s3_in = REGION_NORMAL;
      end else if (sh < VLOW_LIMIT) begin
         region_s3_in = REGION_VLOW;
      end else begin
         region_s3_in = REGION_LOW;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe.en[STG_FIRST]) begin
         d1_s3_ff     <= d1_s2_ff;
         temp_s3_ff   <= temp_s3_in;
         a_s3_ff      <= sh;
         b_s3_ff      <= b_s3_in;
         off_s3_ff    <= off_s3_in;
         sens_s3_ff   <= sens_s3_in;
         // T2 only below 20 C
         t2_s3_ff     <= sh[18] ? dsq_s2_ff[48:31] : 18'd0;
         region_s3_ff <= region_s3_in;
      end
   end

   // squares stay below 2^35 for any input pattern
   assign sq1_full = a_s3_ff * a_s3_ff;
   assign sq2_full = b_s3_ff * b_s3_ff;

   always_comb begin
      out_in.d1     = d1_s3_ff;
      out_in.temp   = temp_s3_ff;
      out_in.t2     = t2_s3_ff;
      out_in.off    = off_s3_ff;
      out_in.sens   = sens_s3_ff;
      out_in.region = region_s3_ff;
      out_in.sq1    = sq1_full[35:0];
      out_in.sq2    = sq2_full[35:0];
   end

   always_ff @(posedge clock) begin
      if (pipe.en[STG_SQ]) begin
         out_ff <= out_in;
      end
   end

   assign first_out = out_ff;

endmodule

>>> rtl/bptc_second.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_second
// Second-order correction: OFF2/SENS2 from the squares, then the corrected
// TEMP, OFF and SENS.
// ----------------------------------------------------------------------------
module bptc_second
   import bptc_pkg::*;
(
   input  logic           clock,
   input  pipe_ctrl_type  pipe,
   input  first_out_type  first_in,
   output second_out_type second_out
);

   logic [39:0] s1, s2;
   logic [39:0] five1, seven2, eleven2;
   logic [39:0] off2_in, sens2_in;

   logic [39:0] off2_ff, sens2_ff;
   logic [23:0] d1_ff;
   logic [19:0] temp_ff;
   logic [17:0] t2_ff;
   logic [35:0] off_ff;
   logic [34:0] sens_ff;
   logic [1:0]  region_ff;

   second_out_type out_ff, out_in;

   assign s1      = {4'h0, first_in.sq1};
   assign s2      = {4'h0, first_in.sq2};
   assign five1   = (s1 << 2) + s1;
   assign seven2  = (s2 << 3) - s2;
   assign eleven2 = (s2 << 3) + (s2 << 1) + s2;

   always_comb begin
      case (first_in.region)
         REGION_LOW: begin
            off2_in  = five1 >> 1;
            sens2_in = five1 >> 2;
         end
         REGION_VLOW: begin
            off2_in  = (five1 >> 1) + seven2;
            sens2_in = (five1 >> 2) + (eleven2 >> 1);
         end
         default: begin
            off2_in  = '0;
            sens2_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pipe.en[STG_CORR]) begin
         off2_ff   <= off2_in;
         sens2_ff  <= sens2_in;
         d1_ff     <= first_in.d1;
         temp_ff   <= first_in.temp;
         t2_ff     <= first_in.t2;
         off_ff    <= first_in.off;
         sens_ff   <= first_in.sens;
         region_ff <= first_in.region;
      end
   end

   always_comb begin
      out_in.d1     = d1_ff;
      out_in.region = region_ff;
      out_in.temp   = $signed({temp_ff[19], temp_ff}) - $signed({3'b000, t2_ff});
      out_in.off    = $signed({{5{off_ff[35]}}, off_ff}) - $signed({1'b0, off2_ff});
      out_in.sens   = $signed({{6{sens_ff[34]}}, sens_ff}) - $signed({1'b0, sens2_ff});
   end

   always_ff @(posedge clock) begin
      if (pipe.en[STG_APPLY]) begin
         out_ff <= out_in;
      end
   end

   assign second_out = out_ff;

endmodule

>>> rtl/bptc_press.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_press
// Pressure: D1*SENS as two partial products, their sum, the offset
// subtraction and the final output register.
// ----------------------------------------------------------------------------
module bptc_press
   import bptc_pkg::*;
(
   input  logic           clock,
   input  pipe_ctrl_type  pipe,
   input  second_out_type second_in,
   output logic [31:0]    temperature_centi,
   output logic [31:0]    pressure_centi,
   output logic [1:0]     temp_region
);

   // stage 7
   logic [43:0]        pl_ff, pl_in;
   logic signed [45:0] ph_ff, ph_in;
   logic [20:0]        temp_p1_ff;
   logic [40:0]        off_p1_ff;
   logic [1:0]         region_p1_ff;

   // stage 8
   logic signed [65:0] prod_ff, prod_in;
   logic [20:0]        temp_p2_ff;
   logic [40:0]        off_p2_ff;
   logic [1:0]         region_p2_ff;

   // stage 9
   logic signed [45:0] diff;
   logic [31:0]        temp_out_ff, temp_out_in;
   logic [31:0]        press_out_ff, press_out_in;
   logic [1:0]         region_out_ff;

   assign pl_in = {20'h0, second_in.d1} * {24'h0, second_in.sens[19:0]};
   assign ph_in = $signed({1'b0, second_in.d1}) * $signed(second_in.sens[40:20]);

   always_ff @(posedge clock) begin
      if (pipe.en[STG_PPROD]) begin
         pl_ff        <= pl_in;
         ph_ff        <= ph_in;
         temp_p1_ff   <= second_in.temp;
         off_p1_ff    <= second_in.off;
         region_p1_ff <= second_in.region;
      end
   end

   assign prod_in = $signed({ph_ff, 20'h00000}) + $signed({22'h0, pl_ff});

   always_ff @(posedge clock) begin
      if (pipe.en[STG_PSUM]) begin
         prod_ff      <= prod_in;
         temp_p2_ff   <= temp_p1_ff;
         off_p2_ff    <= off_p1_ff;
         region_p2_ff <= region_p1_ff;
      end
   end

   // both results fit 32 bits for every input pattern, so no clipping
   assign diff         = $signed(prod_ff[65:21]) - $signed({{4{off_p2_ff[40]}}, off_p2_ff});
   assign press_out_in = {diff[45], diff[45:15]};
   assign temp_out_in  = {{11{temp_p2_ff[20]}}, temp_p2_ff};

   always_ff @(posedge clock) begin
      if (pipe.en[STG_OUT]) begin
         temp_out_ff   <= temp_out_in;
         press_out_ff  <= press_out_in;
         region_out_ff <= region_p2_ff;
      end
   end

   assign temperature_centi = temp_out_ff;
   assign pressure_centi    = press_out_ff;
   assign temp_region       = region_out_ff;

endmodule

>>> rtl/baro_pressure_temp_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Second-order compensated temperature (0.01 C) and pressure (0.01 mbar)
// from raw 24-bit conversions and six calibration words.
//
//   channel  dir  fields
//   req_     in   tdata: pressure_raw[23:0], temperature_raw[47:24]
//   rsp_     out  tdata: temperature_centi[31:0], pressure_centi[63:32],
//                        temp_region[65:64]
//   csr_     in   APB, calibration words C1..C6 at 0x00..0x14
//
// One request per cycle while the output is not stalled; the stage chain is
// dT, products, first-order terms, squares, correction, apply, two
// partial products of D1*SENS, their sum, offset and output register.
// Reset clears the valid bits and the calibration words.
// Stalls: a stage loads when it is empty or its successor moves, so
// bubbles close up while rsp_tready is low.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation
   import bptc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [23:0] pressure_raw, [47:24] temperature_raw
   input  logic [REQ_DATA_W-1:0] req_tdata,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] temperature_centi, [63:32] pressure_centi, [65:64] temp_region
   output logic [RSP_DATA_W-1:0] rsp_tdata,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   coeff_type      coeff;
   pipe_ctrl_type  pipe;
   first_out_type  first_out;
   second_out_type second_out;
   logic [31:0]    temperature_centi;
   logic [31:0]    pressure_centi;
   logic [1:0]     temp_region;

   bptc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coeff       (coeff)
   );

   bptc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .pipe       (pipe)
   );

   bptc_first u_first (
      .clock           (clock),
      .pipe            (pipe),
      .coeff           (coeff),
      .pressure_raw    (req_tdata[23:0]),
      .temperature_raw (req_tdata[47:24]),
      .first_out       (first_out)
   );

   bptc_second u_second (
      .clock      (clock),
      .pipe       (pipe),
      .first_in   (first_out),
      .second_out (second_out)
   );

   bptc_press u_press (
      .clock             (clock),
      .pipe              (pipe),
      .second_in         (second_out),
      .temperature_centi (temperature_centi),
      .pressure_centi    (pressure_centi),
      .temp_region       (temp_region)
   );

   assign rsp_tdata = {6'h00, temp_region, pressure_centi, temperature_centi};

   // empty output stage means the whole pipe can take a request
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipeline stalled with empty output stage");

   a_normal_region_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (temp_region == REGION_NORMAL) |-> $signed(temperature_centi) >= 32'sd2000)
      else $error("normal region with temperature below 20 C");

   a_low_region_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (temp_region == REGION_LOW || temp_region == REGION_VLOW)
      |-> $signed(temperature_centi) < 32'sd2000)
      else $error("low region with temperature at or above 20 C");

   a_region_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> temp_region != 2'd3)
      else $error("invalid temperature region");

endmodule

>>> verif/baro_pressure_temp_compensation_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_test
// Self-checking bench for the pressure / temperature compensation pipeline.
// Directed rows cover the reset calibration, all-zero and all-one words,
// the raw input extremes and the edges of the three temperature regions.
// Random phases follow, each with a fresh calibration and one of four mixes of
// request gaps and response stalls. Every response is compared with its row's
// stated reading or a 64-bit integer prediction of the second-order compensation.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_test;
   import bptc_pkg::*;

   localparam int WATCHDOG_CYCLES = 2000;
   localparam int TAIL_CYCLES     = 20;
   localparam int PHASE_COUNT     = 8;
   localparam int PHASE_READINGS  = 63;
   localparam int MAX_REPORTS     = 100;

   typedef logic [5:0][15:0] cal_set_t;   // [REG_SENS] = C1 .. [REG_TEMPSENS] = C6

   typedef struct packed {
      logic signed [31:0] temp_centi;
      logic signed [31:0] press_centi;
      logic [1:0]         region;
   } reading_t;

   typedef struct packed {
      logic [2:0]  cal_sel;   // 0 keeps the loaded calibration
      logic [23:0] d1;
      logic [23:0] d2;
      logic        known;
      reading_t    want;
   } dir_row_t;

   localparam reading_t AT_REF_ZERO = '{32'sd2000, 32'sd0, REGION_NORMAL};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cal_set_t cal_model = '0;
   reading_t pending_readings [$];
   reading_t rsp_want;
   int       error_count = 0;
   int       idle_cycles = 0;
   int       send_idle_pct = 0;
   int       stall_pct = 0;
   int       send_idle_by_mode [4] = '{0, 45, 0, 38};
   int       stall_by_mode [4] = '{0, 0, 45, 38};

   // {C6, C5, C4, C3, C2, C1}
   cal_set_t cal_sets [6] = '{
      '0,
      {16'd28312, 16'd33464, 16'd23282, 16'd23317, 16'd36924, 16'd40127},
      {16'd32768, 16'd32768, 16'd23000, 16'd23000, 16'd36000, 16'd40000},
      {6{16'hFFFF}},
      {16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000},
      {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF}
   };

   dir_row_t dir_rows [22] = '{
      // reset calibration: every word zero
      '{3'd0, 24'h000000, 24'h000000, 1'b1, AT_REF_ZERO},
      '{3'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, AT_REF_ZERO},
      '{3'd0, 24'hFFFFFF, 24'h000000, 1'b1, AT_REF_ZERO},
      '{3'd0, 24'h000000, 24'hFFFFFF, 1'b1, AT_REF_ZERO},
      // typical calibration
      '{3'd1, 24'd9085466, 24'd8569150, 1'b0, '0},
      '{3'd0, 24'h000000, 24'h000000, 1'b0, '0},
      '{3'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{3'd0, 24'h800000, 24'h7FFFFF, 1'b0, '0},
      // region edges: TEMP = 2000, 1999, -1500, -1501
      '{3'd2, 24'd9085466, 24'd8388608, 1'b0, '0},
      '{3'd0, 24'd9085466, 24'd8388607, 1'b0, '0},
      '{3'd0, 24'd9085466, 24'd7492608, 1'b0, '0},
      '{3'd0, 24'd9085466, 24'd7492352, 1'b0, '0},
      '{3'd0, 24'hFFFFFF, 24'h000000, 1'b0, '0},
      // all words at full scale
      '{3'd3, 24'h000000, 24'h000000, 1'b0, '0},
      '{3'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{3'd0, 24'hFFFFFF, 24'h000000, 1'b0, '0},
      '{3'd0, 24'h000000, 24'hFFFFFF, 1'b0, '0},
      // hottest reading
      '{3'd4, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{3'd0, 24'hFFFFFF, 24'h000000, 1'b0, '0},
      // coldest reading, then D2 right at the reference
      '{3'd5, 24'hFFFFFF, 24'h000000, 1'b0, '0},
      '{3'd0, 24'h000000, 24'h000000, 1'b0, '0},
      '{3'd0, 24'h000000, 24'hFFFF00, 1'b1, AT_REF_ZERO}
   };

   baro_pressure_temp_compensation dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // second-order compensation on the calibration copy, 64-bit signed
   function automatic reading_t compensate(input logic [23:0] d1_raw,
                                           input logic [23:0] d2_raw);
      longint   d1, c1, c2, c3, c4, c5, c6;
      longint   dt, temp, off, sens, t2, off2, sens2, sq, press;
      reading_t r;
      d1 = d1_raw;
      c1 = cal_model[REG_SENS];
      c2 = cal_model[REG_OFF];
      c3 = cal_model[REG_TCS];
      c4 = cal_model[REG_TCO];
      c5 = cal_model[REG_TREF];
      c6 = cal_model[REG_TEMPSENS];
      dt = longint'(d2_raw) - c5 * 256;
      temp = 2000 + ((dt * c6) >>> 23);
      off = c2 * 65536 + ((c4 * dt) >>> 7);
      sens = c1 * 32768 + ((c3 * dt) >>> 8);
      t2 = 0;
      off2 = 0;
      sens2 = 0;
      r.region = REGION_NORMAL;
      if (temp < 2000) begin
         r.region = REGION_LOW;
         t2 = (dt * dt) >>> 31;
         sq = (temp - 2000) * (temp - 2000);
         off2 = (5 * sq) >>> 1;
         sens2 = (5 * sq) >>> 2;
         if (temp < -1500) begin
            r.region = REGION_VLOW;
            sq = (temp + 1500) * (temp + 1500);
            off2 += 7 * sq;
            sens2 += (11 * sq) >>> 1;
         end
      end
      temp -= t2;
      off -= off2;
      sens -= sens2;
      press = (((d1 * sens) >>> 21) - off) >>> 15;
      r.temp_centi = clamp32(temp);
      r.press_centi = clamp32(press);
      return r;
   endfunction

   task automatic flag_mismatch(input string msg);
      if (error_count < MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic csr_write(input int idx, input logic [15:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = CSR_ADDR_W'(idx * 4);
      csr_pwdata = {16'($urandom), value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      if (idx <= REG_TEMPSENS) cal_model[idx] = value;
   endtask

   task automatic csr_check(input int idx);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = CSR_ADDR_W'(idx * 4);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {16'd0, cal_model[idx]})
         flag_mismatch($sformatf("register %0d read %h, want %h", idx, csr_prdata,
                                 cal_model[idx]));
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic load_calibration(input cal_set_t cal);
      for (int idx = REG_SENS; idx <= REG_TEMPSENS; idx++) csr_write(idx, cal[idx]);
      // unmapped indexes must not disturb the words
      for (int idx = REG_TEMPSENS + 1; idx < (1 << $bits(REG_SENS)); idx++)
         csr_write(idx, 16'($urandom));
      for (int idx = REG_SENS; idx <= REG_TEMPSENS; idx++) csr_check(idx);
   endtask

   task automatic send_reading(input logic [23:0] d1, input logic [23:0] d2,
                               input reading_t want);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         req_tdata = REQ_DATA_W'({$urandom, $urandom});
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {d2, d1};
      do @(posedge clock); while (!req_tready);
      pending_readings.push_back(want);
   endtask

   task automatic wait_for_readings();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   always @(negedge clock) rsp_tready = ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            flag_mismatch($sformatf("response %h with no request outstanding", rsp_tdata));
         end else begin
            rsp_want = pending_readings.pop_front();
            if (rsp_tdata[31:0] !== rsp_want.temp_centi ||
                rsp_tdata[63:32] !== rsp_want.press_centi ||
                rsp_tdata[65:64] !== rsp_want.region ||
                rsp_tdata[RSP_DATA_W-1:66] !== '0)
               flag_mismatch($sformatf("temp %0d/%0d press %0d/%0d region %0d/%0d pad %h",
                  $signed(rsp_tdata[31:0]), rsp_want.temp_centi,
                  $signed(rsp_tdata[63:32]), rsp_want.press_centi,
                  rsp_tdata[65:64], rsp_want.region, rsp_tdata[RSP_DATA_W-1:66]));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("watchdog: no progress for %0d cycles", WATCHDOG_CYCLES);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      cal_set_t    cal;
      logic [23:0] d1;
      logic [23:0] d2;
      int          ref_point;
      int          span;
      int          mode;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].cal_sel != 0) begin
            wait_for_readings();
            load_calibration(cal_sets[dir_rows[i].cal_sel]);
         end
         send_reading(dir_rows[i].d1, dir_rows[i].d2,
                      dir_rows[i].known ? dir_rows[i].want
                                        : compensate(dir_rows[i].d1, dir_rows[i].d2));
      end

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         wait_for_readings();
         mode = ph % 4;
         send_idle_pct = send_idle_by_mode[mode];
         stall_pct = stall_by_mode[mode];
         for (int idx = REG_SENS; idx <= REG_TEMPSENS; idx++) begin
            if (ph % 3 == 1) cal[idx] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            else cal[idx] = 16'($urandom);
         end
         load_calibration(cal);
         for (int n = 0; n < PHASE_READINGS; n++) begin
            case ($urandom_range(9))
               0: d1 = 24'h000000;
               1: d1 = 24'hFFFFFF;
               default: d1 = 24'($urandom);
            endcase
            ref_point = int'(cal_model[REG_TREF]) * 256;
            span = int'($urandom & ((32'd1 << $urandom_range(1, 24)) - 1));
            case ($urandom_range(4))
               0: d2 = 24'($urandom);
               1: d2 = (ref_point + span > 24'hFFFFFF) ? 24'hFFFFFF : 24'(ref_point + span);
               2: d2 = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
               default: d2 = (ref_point < span) ? 24'h000000 : 24'(ref_point - span);
            endcase
            send_reading(d1, d2, compensate(d1, d2));
         end
      end

      wait_for_readings();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_readings.size() != 0) flag_mismatch("readings still outstanding");
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
